FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the neuron core.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SNC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Expression must never be true outside reset.
`define SNC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define SNC_ASSERT(lbl, clk, rst_n, prop)
`define SNC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: src/snc_pkg.sv
// Types and constants of the spiking neuron core.
// No dependencies; used by spiking_neuron_core_update.
`timescale 1ns / 1ps

package snc_pkg;

	// Operation carried by an input item.
	typedef enum logic [1:0] {
		MODE_SPIKE    = 2'd0,
		MODE_ROW      = 2'd1,
		MODE_SETTINGS = 2'd2,
		MODE_WEIGHTS  = 2'd3
	} mode_t;

	// Control of the top level.
	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// Layout of one neuron word: potential, settings, then the weight bytes.
	localparam int POT_LSB   = 0;
	localparam int DEST_LSB  = 8;
	localparam int NEG_LSB   = 16;
	localparam int POS_LSB   = 24;
	localparam int LEAK_LSB  = 32;
	localparam int RST_LSB   = 40;
	localparam int WGT_LSB   = 48;

	// Bit position of the potential within a settings write.
	localparam int WR_POT_LSB = 40;
	localparam int WR_SET_W   = 40;

endpackage

FILE: src/snc_ram.sv
// Generic single-clock RAM: one write port with bit mask, one read port.
// Read data is registered and holds while the read enable is low.
`timescale 1ns / 1ps

module snc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [WIDTH-1:0]                      wmask,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/spiking_neuron_core_update.sv
// Write items (row, settings, weights) give no result. A spike item gives
// NUM_NEURONS results, one per cycle while the receiver takes them: each
// neuron word is read into the memory output register, then its result into
// the result register. No new item is taken before the final result is pushed.
// Reset clears the control only; the memories are not cleared and each entry
// must be written before a spike reads it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spiking_neuron_core_update #(
	parameter int NUM_AXONS   = 256,
	parameter int NUM_NEURONS = 32,
	parameter int NUM_WEIGHTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  axon_id,
	input  logic [4:0]  neuron_index,
	input  logic [47:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  neuron_number,
	output logic        fired,
	output logic [7:0]  target_axon,
	output logic        last
);

	// Widths that follow from the parameters.
	localparam int AXW    = $clog2(NUM_AXONS);
	localparam int NIW    = (NUM_NEURONS > 1) ? $clog2(NUM_NEURONS) : 1;
	localparam int CW     = $clog2(NUM_NEURONS + 1);
	localparam int WIW    = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
	localparam int WGT_W  = 8 * NUM_WEIGHTS;
	localparam int WORD_W = snc_pkg::WGT_LSB + WGT_W;

	// The crossbar memory holds one row of connection bits per axon. The neuron
	// memory holds, per neuron, its potential, its settings and its weights, so a
	// spike walks it with one read and at most one masked write-back per cycle while results are taken.
	logic                   xbar_we;
	logic [AXW-1:0]         xbar_addr;
	logic [NUM_NEURONS-1:0] xbar_wdata;
	logic                   xbar_re;
	logic [NUM_NEURONS-1:0] xbar_rdata;

	logic               nrn_we;
	logic [NIW-1:0]     nrn_waddr;
	logic [WORD_W-1:0]  nrn_wdata;
	logic [WORD_W-1:0]  nrn_wmask;
	logic               nrn_re;
	logic [NIW-1:0]     nrn_raddr;
	logic [WORD_W-1:0]  nrn_rdata;

	snc_ram #(
		.WIDTH(NUM_NEURONS),
		.DEPTH(NUM_AXONS)
	) u_xbar_ram (
		.clk   (clk),
		.we    (xbar_we),
		.waddr (xbar_addr),
		.wdata (xbar_wdata),
		.wmask ({NUM_NEURONS{1'b1}}),
		.re    (xbar_re),
		.raddr (xbar_addr),
		.rdata (xbar_rdata)
	);

	snc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_NEURONS)
	) u_nrn_ram (
		.clk   (clk),
		.we    (nrn_we),
		.waddr (nrn_waddr),
		.wdata (nrn_wdata),
		.wmask (nrn_wmask),
		.re    (nrn_re),
		.raddr (nrn_raddr),
		.rdata (nrn_rdata)
	);

	// Control registers.
	snc_pkg::state_t state_q, state_d;
	logic [CW-1:0]   rd_cnt_q;     // next neuron to read during a walk
	logic [WIW-1:0]  w_cnt_q;      // weight slot of that neuron
	logic            axon_ok_q;    // spike axon lies inside the crossbar
	logic            valid_s2;     // neuron word in the memory output is live
	logic [NIW-1:0]  idx_s2;
	logic [WIW-1:0]  w_s2;
	logic            out_valid_q;

	// Result registers.
	logic [4:0] neuron_number_q;
	logic       fired_q;
	logic [7:0] dest_q;
	logic       last_q;

	// Decode of the input item.
	snc_pkg::mode_t in_mode;
	logic           in_accept;
	logic           axon_in_range;
	logic           nidx_in_range;

	assign in_mode       = snc_pkg::mode_t'(mode);
	assign in_accept     = in_valid && in_ready;
	assign axon_in_range = 32'(axon_id) < NUM_AXONS;
	assign nidx_in_range = 32'(neuron_index) < NUM_NEURONS;
	assign in_ready      = (state_q == snc_pkg::ST_IDLE);

	// The walk moves when the compute stage is empty or its result has a slot.
	logic adv;
	logic issue;
	logic rd_done;

	assign adv     = !valid_s2 || !out_valid_q || out_ready;
	assign rd_done = (rd_cnt_q == CW'(NUM_NEURONS));
	assign issue   = (state_q == snc_pkg::ST_WALK) && adv && !rd_done;

	// Neuron update in signed 8-bit wrapping arithmetic.
	logic       conn;
	logic [7:0] pot, wgt, leak, rst_pot, pos_th, neg_th, dest, sum;
	logic [7:0] new_pot;
	logic       fire_now;

	always_comb begin
		conn     = axon_ok_q && xbar_rdata[idx_s2];
		pot      = nrn_rdata[snc_pkg::POT_LSB +: 8];
		rst_pot  = nrn_rdata[snc_pkg::RST_LSB +: 8];
		leak     = nrn_rdata[snc_pkg::LEAK_LSB +: 8];
		pos_th   = nrn_rdata[snc_pkg::POS_LSB +: 8];
		neg_th   = nrn_rdata[snc_pkg::NEG_LSB +: 8];
		dest     = nrn_rdata[snc_pkg::DEST_LSB +: 8];
		wgt      = nrn_rdata[snc_pkg::WGT_LSB + 8 * w_s2 +: 8];
		sum      = pot + wgt - leak;
		fire_now = 1'b0;
		new_pot  = sum;
		if ($signed(sum) > $signed(pos_th)) begin
			fire_now = 1'b1;
			new_pot  = rst_pot;
		end else if ($signed(sum) < $signed(neg_th)) begin
			new_pot = rst_pot;
		end
	end

	// Memory ports. Write items use the ports only in idle; the walk owns them
	// otherwise. The walk reads neuron j+1 while it writes back neuron j.
	always_comb begin
		xbar_addr  = AXW'(axon_id);
		xbar_wdata = NUM_NEURONS'(write_data);
		xbar_we    = 1'b0;
		xbar_re    = 1'b0;
		nrn_we     = 1'b0;
		nrn_waddr  = NIW'(neuron_index);
		nrn_wdata  = '0;
		nrn_wmask  = '0;
		nrn_re     = issue;
		nrn_raddr  = rd_cnt_q[NIW-1:0];
		if (state_q == snc_pkg::ST_WALK) begin
			if (adv && valid_s2 && conn) begin
				nrn_we    = 1'b1;
				nrn_waddr = idx_s2;
				nrn_wdata[snc_pkg::POT_LSB +: 8] = new_pot;
				nrn_wmask[snc_pkg::POT_LSB +: 8] = 8'hff;
			end
		end else if (in_accept) begin
			case (in_mode)
				snc_pkg::MODE_SPIKE: begin
					xbar_re = 1'b1;
				end
				snc_pkg::MODE_ROW: begin
					xbar_we = axon_in_range;
				end
				snc_pkg::MODE_SETTINGS: begin
					nrn_we = nidx_in_range;
					nrn_wdata[snc_pkg::POT_LSB +: 8] = write_data[snc_pkg::WR_POT_LSB +: 8];
					nrn_wdata[snc_pkg::DEST_LSB +: snc_pkg::WR_SET_W] =
						write_data[snc_pkg::WR_SET_W-1:0];
					nrn_wmask[snc_pkg::WGT_LSB-1:0] = '1;
				end
				snc_pkg::MODE_WEIGHTS: begin
					nrn_we = nidx_in_range;
					nrn_wdata[snc_pkg::WGT_LSB +: WGT_W] = WGT_W'(write_data);
					nrn_wmask[snc_pkg::WGT_LSB +: WGT_W] = '1;
				end
				default: begin
					xbar_re = 1'b0;
				end
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			snc_pkg::ST_IDLE: begin
				if (in_accept && in_mode == snc_pkg::MODE_SPIKE) begin
					state_d = snc_pkg::ST_WALK;
				end
			end
			snc_pkg::ST_WALK: begin
				if (adv && valid_s2 && idx_s2 == NIW'(NUM_NEURONS - 1)) begin
					state_d = snc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = snc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= snc_pkg::ST_IDLE;
			rd_cnt_q    <= '0;
			w_cnt_q     <= '0;
			axon_ok_q   <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept && in_mode == snc_pkg::MODE_SPIKE) begin
				rd_cnt_q  <= '0;
				w_cnt_q   <= '0;
				axon_ok_q <= axon_in_range;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
				if (w_cnt_q == WIW'(NUM_WEIGHTS - 1)) begin
					w_cnt_q <= '0;
				end else begin
					w_cnt_q <= w_cnt_q + WIW'(1);
				end
			end
			if (adv) begin
				valid_s2 <= issue;
			end
			if (adv && valid_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage tags and result payload.
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s2 <= rd_cnt_q[NIW-1:0];
			w_s2   <= w_cnt_q;
		end
		if (adv && valid_s2) begin
			neuron_number_q <= 5'(idx_s2);
			fired_q         <= conn && fire_now;
			dest_q          <= (conn && fire_now) ? dest : 8'd0;
			last_q          <= (idx_s2 == NIW'(NUM_NEURONS - 1));
		end
	end

	assign out_valid     = out_valid_q;
	assign neuron_number = neuron_number_q;
	assign fired         = fired_q;
	assign target_axon   = dest_q;
	assign last          = last_q;

	// A spike always starts its walk at neuron zero.
	`SNC_ASSERT(a_walk_start, clk, arst_n, (in_accept && in_mode == snc_pkg::MODE_SPIKE) |=> (state_q == snc_pkg::ST_WALK && rd_cnt_q == '0))
	// Write-back never lands on the entry being read in the same cycle.
	`SNC_ASSERT_NEVER(a_rw_same_entry, clk, arst_n, nrn_re && nrn_we && nrn_raddr == nrn_waddr)
	// A result without a spike carries no destination.
	`SNC_ASSERT(a_dest_zero, clk, arst_n, (out_valid && !fired) |-> target_axon == 8'd0)
	// The final result of a spike reports the highest neuron.
	`SNC_ASSERT(a_last_number, clk, arst_n, (out_valid && last) |-> neuron_number == 5'(NUM_NEURONS - 1))
	// Pushing the final result ends the walk.
	`SNC_ASSERT(a_walk_end, clk, arst_n, (state_q == snc_pkg::ST_WALK && adv && valid_s2 && idx_s2 == NIW'(NUM_NEURONS - 1)) |=> state_q == snc_pkg::ST_IDLE)

endmodule

FILE: dv/spiking_neuron_core_update_checker.sv
// Checker for the spiking neuron core: tracks the crossbar and neuron tables
// from the accepted write items and predicts the per-neuron reports of each spike.
// Depends on snc_pkg for the mode codes.
`timescale 1ns / 1ps

module spiking_neuron_core_update_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  axon_id,
	input  logic [4:0]  neuron_index,
	input  logic [47:0] write_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [4:0]  neuron_number,
	input  logic        fired,
	input  logic [7:0]  target_axon,
	input  logic        last,
	output int          mismatch_count,
	output int          reports_outstanding
);

	typedef struct packed {
		logic [4:0] neuron;
		logic       fired;
		logic [7:0] dest_axon;
		logic       last;
	} neuron_report_t;

	// Shadow of the core's tables.
	logic [31:0]        crossbar      [256];
	logic signed [7:0]  membrane      [32];
	logic signed [7:0]  reset_pot     [32];
	logic signed [7:0]  leak          [32];
	logic signed [7:0]  pos_thresh    [32];
	logic signed [7:0]  neg_thresh    [32];
	logic [7:0]         dest          [32];
	logic signed [7:0]  syn_weight    [32][4];

	neuron_report_t expected_reports[$];
	int fault_total = 0;

	// One spike walks all neurons in order; connected ones integrate.
	function automatic void integrate_spike(input logic [7:0] axon);
		logic signed [7:0] p;
		neuron_report_t rpt;
		for (int n = 0; n < 32; n++) begin
			rpt.neuron = n[4:0];
			rpt.fired = 1'b0;
			rpt.dest_axon = 8'd0;
			rpt.last = (n == 31);
			if (crossbar[axon][n]) begin
				p = membrane[n] + syn_weight[n][n % 4] - leak[n];
				if (p > pos_thresh[n]) begin
					p = reset_pot[n];
					rpt.fired = 1'b1;
					rpt.dest_axon = dest[n];
				end else if (p < neg_thresh[n]) begin
					p = reset_pot[n];
				end
				membrane[n] = p;
			end
			expected_reports.push_back(rpt);
		end
	endfunction

	function automatic void absorb_item(input logic [1:0] op, input logic [7:0] axon,
			input logic [4:0] nidx, input logic [47:0] data);
		case (op)
			snc_pkg::MODE_SPIKE: begin
				integrate_spike(axon);
			end
			snc_pkg::MODE_ROW: begin
				crossbar[axon] = data[31:0];
			end
			snc_pkg::MODE_SETTINGS: begin
				membrane[nidx]   = data[47:40];
				reset_pot[nidx]  = data[39:32];
				leak[nidx]       = data[31:24];
				pos_thresh[nidx] = data[23:16];
				neg_thresh[nidx] = data[15:8];
				dest[nidx]       = data[7:0];
			end
			snc_pkg::MODE_WEIGHTS: begin
				for (int w = 0; w < 4; w++)
					syn_weight[nidx][w] = data[8 * w +: 8];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_report();
		neuron_report_t want;
		if (expected_reports.size() == 0) begin
			$error("unexpected result: neuron_number %0d fired %0d target_axon %0d",
				neuron_number, fired, target_axon);
			fault_total++;
			return;
		end
		want = expected_reports.pop_front();
		if (neuron_number !== want.neuron) begin
			$error("neuron_number: expected %0d, got %0d", want.neuron, neuron_number);
			fault_total++;
		end
		if (fired !== want.fired) begin
			$error("fired (neuron %0d): expected %0d, got %0d", want.neuron, want.fired, fired);
			fault_total++;
		end
		if (target_axon !== want.dest_axon) begin
			$error("target_axon (neuron %0d): expected %0d, got %0d",
				want.neuron, want.dest_axon, target_axon);
			fault_total++;
		end
		if (last !== want.last) begin
			$error("last (neuron %0d): expected %0d, got %0d", want.neuron, want.last, last);
			fault_total++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				absorb_item(mode, axon_id, neuron_index, write_data);
			if (out_valid && out_ready)
				check_report();
		end
		mismatch_count <= fault_total;
		reports_outstanding <= expected_reports.size();
	end

endmodule

FILE: dv/spiking_neuron_core_update_test.sv
// Top of the spiking neuron core testbench: clock, reset, item stimulus and
// verdict. Depends on snc_pkg, spiking_neuron_core_update and the checker.
`timescale 1ns / 1ps

module spiking_neuron_core_update_test;

	// Far above the slowest legal run: every spike gives 32 reports, and the
	// receiver may sit idle most of the time or hold off for a long stretch.
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS    = 95;
	localparam int SETTLE_CYCLES  = 40;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [7:0]  axon_id;
	logic [4:0]  neuron_index;
	logic [47:0] write_data;
	logic        out_valid;
	logic        out_ready;
	logic [4:0]  neuron_number;
	logic        fired;
	logic [7:0]  target_axon;
	logic        last;

	int mismatch_count;
	int reports_outstanding;

	// Idle rates in percent for the sending and the receiving side.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	// Set by the stimulus, consumed by the receiver process.
	bit long_hold_request = 0;

	// Rows that have been written; a spike may only travel on one of these,
	// since the crossbar holds garbage until a row is loaded.
	bit       row_loaded [256];
	int       loaded_rows[$];

	spiking_neuron_core_update dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.axon_id       (axon_id),
		.neuron_index  (neuron_index),
		.write_data    (write_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.neuron_number (neuron_number),
		.fired         (fired),
		.target_axon   (target_axon),
		.last          (last)
	);

	spiking_neuron_core_update_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.mode                (mode),
		.axon_id             (axon_id),
		.neuron_index        (neuron_index),
		.write_data          (write_data),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.neuron_number       (neuron_number),
		.fired               (fired),
		.target_axon         (target_axon),
		.last                (last),
		.mismatch_count      (mismatch_count),
		.reports_outstanding (reports_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Settings write layout: potential, reset, leak, thresholds, destination.
	function automatic logic [47:0] pack_settings(input logic [7:0] pot, input logic [7:0] rst,
			input logic [7:0] lk, input logic [7:0] pos, input logic [7:0] neg,
			input logic [7:0] dst);
		return {pot, rst, lk, pos, neg, dst};
	endfunction

	// Offers one item, optionally after a random gap, and returns at the edge
	// where it was accepted. Valid stays high on return so that a back-to-back
	// item needs only one assignment in the next step.
	task automatic offer_item(input snc_pkg::mode_t op, input logic [7:0] axon,
			input logic [4:0] nidx, input logic [47:0] data);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= op;
		axon_id      <= axon;
		neuron_index <= nidx;
		write_data   <= data;
		do
			@(posedge clk);
		while (!in_ready);
		if (op == snc_pkg::MODE_ROW && !row_loaded[axon]) begin
			row_loaded[axon] = 1'b1;
			loaded_rows.push_back(axon);
		end
	endtask

	// The sender pauses until every predicted report has come back. The first
	// edge lets the checker take in the item accepted at the current edge.
	task automatic wait_all_reports();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (reports_outstanding != 0);
	endtask

	// Mostly spikes on loaded rows, so that potentials build up and neurons
	// fire, mixed with row, settings and weight rewrites with random content.
	task automatic run_random_phase(input int count);
		int pick;
		logic [47:0] data;
		logic [4:0] nidx;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			data = 48'({$urandom, $urandom});
			nidx = 5'($urandom_range(0, 31));
			if (pick < 55) begin
				offer_item(snc_pkg::MODE_SPIKE,
					8'(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)]), nidx, data);
			end else if (pick < 72) begin
				offer_item(snc_pkg::MODE_ROW, 8'($urandom_range(0, 255)), nidx, data);
			end else if (pick < 87) begin
				// Half of the settings writes use small leaks and thresholds near
				// zero so that spikes cross them often; the rest are fully random.
				if ($urandom_range(0, 1)) begin
					data[31:24] = 8'($urandom_range(0, 6));
					data[23:16] = 8'($urandom_range(0, 40));
					data[15:8]  = 8'(-$urandom_range(0, 40));
				end
				offer_item(snc_pkg::MODE_SETTINGS, 8'($urandom_range(0, 255)), nidx, data);
			end else begin
				offer_item(snc_pkg::MODE_WEIGHTS, 8'($urandom_range(0, 255)), nidx, data);
			end
		end
	endtask

	// Receiver: random stalls at the current rate, plus one long hold-off on
	// request so that the core backs up and stops taking items.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_request) begin
				long_hold_request = 1'b0;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Watchdog: a run that has not finished by the limit is a failure.
	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("spiking_neuron_core_update_test: errors");
		$finish;
	end

	initial begin
		in_valid     = 1'b0;
		mode         = snc_pkg::MODE_SPIKE;
		axon_id      = 8'd0;
		neuron_index = 5'd0;
		write_data   = 48'd0;
		arst_n       = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first stretch has the sender idle a little and the receiver a lot.
		tx_idle_pct = 17;
		rx_idle_pct = 64;

		// Every neuron word is loaded before any spike reaches it, since the
		// core reads the whole neuron table on each walk.
		for (int n = 0; n < 32; n++) begin
			offer_item(snc_pkg::MODE_SETTINGS, 8'($urandom_range(0, 255)), 5'(n),
				48'({$urandom, $urandom}));
			offer_item(snc_pkg::MODE_WEIGHTS, 8'($urandom_range(0, 255)), 5'(n),
				48'({$urandom, $urandom}));
		end

		// Directed cases. Row bits above 31 have no neuron behind them: axon 0
		// gets every neuron, while axon 255 gets only the unused high bits and so
		// connects nobody.
		offer_item(snc_pkg::MODE_ROW, 8'd0, 5'd0, 48'hFFFF_FFFF_FFFF);
		offer_item(snc_pkg::MODE_ROW, 8'd255, 5'd31, 48'hFFFF_0000_0000);
		// Neuron 0: top potential plus top weight wraps negative; it can never
		// exceed the largest positive threshold.
		offer_item(snc_pkg::MODE_SETTINGS, 8'd0, 5'd0,
			pack_settings(8'h7F, 8'h00, 8'h00, 8'h7F, 8'h80, 8'hFF));
		offer_item(snc_pkg::MODE_WEIGHTS, 8'd0, 5'd0, 48'hFFFF_7F7F_7F7F);
		// Neuron 1: most negative potential and weight with the largest leak,
		// driven below its negative threshold so that it resets without firing.
		offer_item(snc_pkg::MODE_SETTINGS, 8'd0, 5'd1,
			pack_settings(8'h80, 8'h10, 8'h7F, 8'h7F, 8'h9C, 8'h00));
		offer_item(snc_pkg::MODE_WEIGHTS, 8'd0, 5'd1, 48'h0000_8080_8080);
		// Neuron 2: lowest positive threshold and a negative leak; fires often.
		offer_item(snc_pkg::MODE_SETTINGS, 8'd0, 5'd2,
			pack_settings(8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'hA5));
		// Neuron 3 uses its fourth weight; one step above a zero threshold fires.
		offer_item(snc_pkg::MODE_SETTINGS, 8'd0, 5'd3,
			pack_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A));
		offer_item(snc_pkg::MODE_WEIGHTS, 8'd0, 5'd3, 48'h0000_0100_0000);
		// The highest neuron, which also carries the last flag.
		offer_item(snc_pkg::MODE_SETTINGS, 8'd255, 5'd31,
			pack_settings(8'h00, 8'h01, 8'h01, 8'h01, 8'hFF, 8'h80));
		offer_item(snc_pkg::MODE_SPIKE, 8'd0, 5'd0, 48'd0);
		offer_item(snc_pkg::MODE_SPIKE, 8'd0, 5'd31, 48'hFFFF_FFFF_FFFF);
		offer_item(snc_pkg::MODE_SPIKE, 8'd0, 5'd0, 48'd0);
		offer_item(snc_pkg::MODE_SPIKE, 8'd255, 5'd0, 48'd0);
		offer_item(snc_pkg::MODE_ROW, 8'd1, 5'd0, 48'h0000_5555_AAAA);
		offer_item(snc_pkg::MODE_SPIKE, 8'd1, 5'd0, 48'd0);
		offer_item(snc_pkg::MODE_ROW, 8'd128, 5'd0, 48'hFFFF_8000_0001);
		offer_item(snc_pkg::MODE_SPIKE, 8'd128, 5'd0, 48'd0);
		// A row cleared to zero: the spike leaves every neuron alone.
		offer_item(snc_pkg::MODE_ROW, 8'd0, 5'd0, 48'd0);
		offer_item(snc_pkg::MODE_SPIKE, 8'd0, 5'd0, 48'd0);
		offer_item(snc_pkg::MODE_ROW, 8'd0, 5'd0, 48'h0000_FFFF_FFFF);
		wait_all_reports();

		run_random_phase(PHASE_ITEMS);
		wait_all_reports();

		// Now the sender is the slow side.
		tx_idle_pct = 64;
		rx_idle_pct = 17;
		run_random_phase(PHASE_ITEMS);
		wait_all_reports();

		// Full speed on both sides, with one long receiver hold-off while the
		// sender keeps offering items so that the core fills and stalls its input.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		long_hold_request = 1'b1;
		run_random_phase(PHASE_ITEMS);
		wait_all_reports();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && reports_outstanding == 0) begin
			$display("spiking_neuron_core_update_test: clean");
		end else begin
			$display("spiking_neuron_core_update_test: errors");
		end
		$finish;
	end

endmodule
